@@ rtl/arm_data_processing_execute_assert.svh @@
// assertion macros for the execute block
`ifndef ARM_DATA_PROCESSING_EXECUTE_ASSERT_SVH
`define ARM_DATA_PROCESSING_EXECUTE_ASSERT_SVH

`ifndef SYNTHESIS
`define ADP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADP_ASSERT(lbl, prop, msg) \
  `ADP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ADP_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ADP_ASSERT(lbl, prop, msg)
`endif

`endif

@@ rtl/adp_pkg.sv @@
package adp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegN  = 16;
  localparam int unsigned RegAw = 4;
  localparam int unsigned OpcW  = 4;

  // data-processing opcodes handled here
  typedef enum logic [OpcW-1:0] {
    OPC_MUL = 4'h0,
    OPC_SUB = 4'h2,
    OPC_ADD = 4'h4,
    OPC_CMP = 4'ha,
    OPC_MOV = 4'hd
  } opcode_e;

  typedef enum logic {
    CMD_EXEC = 1'b0,
    CMD_LOAD = 1'b1
  } command_e;

  localparam logic [RegAw-1:0] PC_REG = 4'd15;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic             write_enable;
    logic [RegAw-1:0] dest_reg;
    logic [DataW-1:0] dest_value;
    logic             flags_written;
    flags_t           flags;
    logic             unsupported;
  } result_t;

endpackage

@@ rtl/adp_in_if.sv @@
interface adp_in_if;
  import adp_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [DataW-1:0] instruction_word;
  logic [RegAw-1:0] load_index;
  logic [DataW-1:0] load_value;

  modport source (
    output valid, command, instruction_word, load_index, load_value,
    input  ready
  );

  modport sink (
    input  valid, command, instruction_word, load_index, load_value,
    output ready
  );
endinterface

@@ rtl/adp_out_if.sv @@
interface adp_out_if;
  import adp_pkg::*;

  logic             valid;
  logic             ready;
  logic             write_enable;
  logic [RegAw-1:0] dest_reg;
  logic [DataW-1:0] dest_value;
  logic             flags_written;
  logic             flag_n;
  logic             flag_z;
  logic             flag_c;
  logic             flag_v;
  logic             unsupported;

  modport source (
    output valid, write_enable, dest_reg, dest_value, flags_written,
           flag_n, flag_z, flag_c, flag_v, unsupported,
    input  ready
  );

  modport sink (
    input  valid, write_enable, dest_reg, dest_value, flags_written,
           flag_n, flag_z, flag_c, flag_v, unsupported,
    output ready
  );
endinterface

@@ rtl/adp_regfile.sv @@
module adp_regfile (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [adp_pkg::RegAw-1:0] ra_addr_i,
  input  logic [adp_pkg::RegAw-1:0] rb_addr_i,
  input  logic                      we_i,
  input  logic [adp_pkg::RegAw-1:0] waddr_i,
  input  logic [adp_pkg::DataW-1:0] wdata_i,
  output logic [adp_pkg::DataW-1:0] ra_data_o,
  output logic [adp_pkg::DataW-1:0] rb_data_o
);
  import adp_pkg::*;

  logic [DataW-1:0] mem [RegN];
  logic [RegN-1:0]  vld_q, vld_d;
  logic [DataW-1:0] ra_q, rb_q;
  logic             ra_vld_q, rb_vld_q;

  // entries never written read as zero
  always_comb begin
    vld_d = vld_q;
    if (we_i) begin
      vld_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      ra_vld_q <= 1'b0;
      rb_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (rd_en_i) begin
        ra_vld_q <= (we_i && waddr_i == ra_addr_i) || vld_q[ra_addr_i];
        rb_vld_q <= (we_i && waddr_i == rb_addr_i) || vld_q[rb_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data registered, with bypass of a write at the same edge
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ra_q <= (we_i && waddr_i == ra_addr_i) ? wdata_i : mem[ra_addr_i];
      rb_q <= (we_i && waddr_i == rb_addr_i) ? wdata_i : mem[rb_addr_i];
    end
  end

  assign ra_data_o = ra_vld_q ? ra_q : '0;
  assign rb_data_o = rb_vld_q ? rb_q : '0;

endmodule

@@ rtl/adp_alu.sv @@
module adp_alu (
  input  logic                      command_i,
  input  logic [adp_pkg::DataW-1:0] instr_i,
  input  logic [adp_pkg::RegAw-1:0] load_index_i,
  input  logic [adp_pkg::DataW-1:0] load_value_i,
  input  logic [adp_pkg::DataW-1:0] op_a_i,
  input  logic [adp_pkg::DataW-1:0] op_b_i,
  input  adp_pkg::flags_t           flags_i,
  output adp_pkg::result_t          res_o
);
  import adp_pkg::*;

  logic [OpcW-1:0]    opc;
  logic [RegAw-1:0]   rn, rd;
  logic [DataW-1:0]   imm32, op2, prod;
  logic [2*DataW-1:0] imm_rot;
  logic [4:0]         rot;
  logic               op2_ok;
  logic [DataW:0]     diff;

  assign opc   = instr_i[24:21];
  assign rn    = instr_i[19:16];
  assign rd    = instr_i[15:12];
  assign imm32 = {24'd0, instr_i[7:0]};
  assign rot   = {instr_i[11:8], 1'b0};
  // rotate right through a doubled word
  assign imm_rot = {imm32, imm32} >> rot;
  assign op2_ok  = instr_i[25] || (!instr_i[4] && instr_i[11:7] == 5'd0);
  assign op2     = instr_i[25] ? imm_rot[DataW-1:0] : op_b_i;
  assign prod    = op_a_i * op_b_i;
  assign diff    = {1'b0, op_a_i} - {1'b0, op2};

  always_comb begin
    res_o               = '0;
    res_o.flags         = flags_i;
    if (command_i == CMD_LOAD) begin
      res_o.write_enable = 1'b1;
      res_o.dest_reg     = load_index_i;
      res_o.dest_value   = load_value_i;
    end else begin
      unique case (opcode_e'(opc))
        OPC_MUL: begin
          res_o.write_enable = 1'b1;
          res_o.dest_reg     = rn;
          res_o.dest_value   = prod;
        end
        OPC_SUB, OPC_ADD, OPC_MOV: begin
          if (!op2_ok) begin
            res_o.unsupported = 1'b1;
          end else begin
            res_o.write_enable = 1'b1;
            res_o.dest_reg     = rd;
            if (opcode_e'(opc) == OPC_SUB) begin
              res_o.dest_value = diff[DataW-1:0];
            end else if (opcode_e'(opc) == OPC_ADD) begin
              res_o.dest_value = op_a_i + op2;
            end else begin
              res_o.dest_value = op2;
            end
          end
        end
        OPC_CMP: begin
          if (!op2_ok) begin
            res_o.unsupported = 1'b1;
          end else if (instr_i[20] && rd != PC_REG) begin
            res_o.flags_written = 1'b1;
            res_o.flags.n       = diff[DataW-1];
            res_o.flags.z       = (diff[DataW-1:0] == '0);
            res_o.flags.c       = ~diff[DataW];
            res_o.flags.v       = ((op_a_i[DataW-1] ^ op2[DataW-1]) &
                                   (op_a_i[DataW-1] ^ diff[DataW-1]));
          end
        end
        default: begin
          res_o.unsupported = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/arm_data_processing_execute.sv @@
// channel | interface    | payload
// in_i    | adp_in_if    | command, instruction_word, load_index, load_value
// out_o   | adp_out_if   | write_enable, dest_reg, dest_value, flags_written,
//         |              | flag_n, flag_z, flag_c, flag_v, unsupported
//
// one item per cycle while the output is not stalled; an item taken passes through
// the register file read port and operand stage, then the alu into the result register
// register file and flags are written when an item moves into the result register
// a stalled output holds the item in the operand stage; input ready drops only
// when both stages are full and the output is not taken
// reset clears the register file valid bits, the flags and both stage valids

`include "arm_data_processing_execute_assert.svh"

module arm_data_processing_execute (
  input  logic      clk_i,
  input  logic      rst_ni,
  adp_in_if.sink    in_i,
  adp_out_if.source out_o
);
  import adp_pkg::*;

  logic             s1_valid_q;
  logic             s1_cmd_q;
  logic [DataW-1:0] s1_instr_q;
  logic [RegAw-1:0] s1_lidx_q;
  logic [DataW-1:0] s1_lval_q;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, alu_res;
  flags_t           flags_q;
  logic             adv, in_acc, in_ready;
  logic [RegAw-1:0] ra_addr;
  logic [DataW-1:0] op_a, op_b;

  assign adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || adv;
  assign in_acc   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // multiply reads rs on port a, the rest read rn
  assign ra_addr = (opcode_e'(in_i.instruction_word[24:21]) == OPC_MUL) ?
                   in_i.instruction_word[11:8] : in_i.instruction_word[19:16];

  adp_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .ra_addr_i (ra_addr),
    .rb_addr_i (in_i.instruction_word[3:0]),
    .we_i      (adv && alu_res.write_enable),
    .waddr_i   (alu_res.dest_reg),
    .wdata_i   (alu_res.dest_value),
    .ra_data_o (op_a),
    .rb_data_o (op_b)
  );

  adp_alu u_alu (
    .command_i    (s1_cmd_q),
    .instr_i      (s1_instr_q),
    .load_index_i (s1_lidx_q),
    .load_value_i (s1_lval_q),
    .op_a_i       (op_a),
    .op_b_i       (op_b),
    .flags_i      (flags_q),
    .res_o        (alu_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
      if (adv && alu_res.flags_written) begin
        flags_q <= alu_res.flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= in_i.command;
      s1_instr_q <= in_i.instruction_word;
      s1_lidx_q  <= in_i.load_index;
      s1_lval_q  <= in_i.load_value;
    end
    if (adv) begin
      res_q <= alu_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.write_enable  = res_q.write_enable;
  assign out_o.dest_reg      = res_q.dest_reg;
  assign out_o.dest_value    = res_q.dest_value;
  assign out_o.flags_written = res_q.flags_written;
  assign out_o.flag_n        = res_q.flags.n;
  assign out_o.flag_z        = res_q.flags.z;
  assign out_o.flag_c        = res_q.flags.c;
  assign out_o.flag_v        = res_q.flags.v;
  assign out_o.unsupported   = res_q.unsupported;

  `ADP_ASSERT(a_stall_only_when_full, !in_ready |-> (out_valid_q && !out_o.ready), "input stalled while output free")
  `ADP_ASSERT(a_flags_hold, !(adv && alu_res.flags_written) |=> $stable(flags_q), "flags changed without a compare")
  `ADP_ASSERT(a_uns_no_write, (out_valid_q && res_q.unsupported) |-> (!res_q.write_enable && !res_q.flags_written), "unsupported item had side effects")
  `ADP_ASSERT(a_nowrite_zero, (out_valid_q && !res_q.write_enable) |-> (res_q.dest_reg == '0 && res_q.dest_value == '0), "nonzero destination without write")

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adp_pkg::*;

  typedef struct packed {
    command_e         command;
    logic [DataW-1:0] word;
    logic [RegAw-1:0] load_index;
    logic [DataW-1:0] load_value;
  } op_item_t;

  logic clk;
  logic rst_n;

  adp_in_if  in_if ();
  adp_out_if out_if ();

  arm_data_processing_execute dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // architectural state as the block should see it
  logic [DataW-1:0] arch_regs [RegN];
  flags_t           arch_flags;

  op_item_t instr_queue [$];
  result_t  expected_writebacks [$];

  int       total_items;
  int       accepted_items;
  int       mismatches;
  int       in_gap;
  int       in_calm;
  int       out_stall;
  int       out_calm;
  int       stall_now;
  logic     in_fire;
  logic     out_fire;
  op_item_t next_item;
  result_t  observed;

  // mostly back to back, some short gaps, a few long ones, and calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // returns 0 when the operand uses a shift the block does not support
  function automatic logic shifter_operand(input logic [DataW-1:0] word,
                                           output logic [DataW-1:0] value);
    logic [4:0]       rot;
    logic [DataW-1:0] imm;
    rot   = {word[11:8], 1'b0};
    imm   = {24'd0, word[7:0]};
    value = '0;
    if (word[25]) begin
      value = (rot == 0) ? imm : ((imm >> rot) | (imm << (32 - rot)));
      return 1'b1;
    end
    if (word[4] || word[11:7] != 5'd0) return 1'b0;
    value = arch_regs[word[3:0]];
    return 1'b1;
  endfunction

  function automatic result_t execute_item(input op_item_t it);
    result_t          r;
    logic [OpcW-1:0]  opc;
    logic [RegAw-1:0] rn;
    logic [RegAw-1:0] rd;
    logic [DataW-1:0] op2;
    logic [DataW-1:0] lhs;
    logic [DataW-1:0] diff;
    r   = '0;
    opc = it.word[24:21];
    rn  = it.word[19:16];
    rd  = it.word[15:12];
    if (it.command == CMD_LOAD) begin
      r.write_enable = 1'b1;
      r.dest_reg     = it.load_index;
      r.dest_value   = it.load_value;
    end else begin
      case (opc)
        OPC_MUL: begin
          // multiply names its destination in the rn field
          r.dest_value   = arch_regs[it.word[3:0]] * arch_regs[it.word[11:8]];
          r.dest_reg     = rn;
          r.write_enable = 1'b1;
        end
        OPC_SUB, OPC_ADD, OPC_MOV: begin
          if (!shifter_operand(it.word, op2)) begin
            r.unsupported = 1'b1;
          end else begin
            case (opc)
              OPC_SUB: r.dest_value = arch_regs[rn] - op2;
              OPC_ADD: r.dest_value = arch_regs[rn] + op2;
              default: r.dest_value = op2;
            endcase
            r.dest_reg     = rd;
            r.write_enable = 1'b1;
          end
        end
        OPC_CMP: begin
          if (!shifter_operand(it.word, op2)) begin
            r.unsupported = 1'b1;
          end else if (it.word[20] && rd != PC_REG) begin
            lhs          = arch_regs[rn];
            diff         = lhs - op2;
            arch_flags.n = diff[31];
            arch_flags.z = (diff == '0);
            arch_flags.c = (lhs >= op2);
            arch_flags.v = (lhs[31] ^ op2[31]) & (lhs[31] ^ diff[31]);
            r.flags_written = 1'b1;
          end
        end
        default: r.unsupported = 1'b1;
      endcase
    end
    if (r.write_enable) arch_regs[r.dest_reg] = r.dest_value;
    r.flags = arch_flags;
    return r;
  endfunction

  function automatic logic [DataW-1:0] dp_word(input logic [OpcW-1:0] opc, input logic imm,
                                               input logic s, input logic [3:0] rn,
                                               input logic [3:0] rd, input logic [11:0] src2);
    return {4'he, 2'b00, imm, opc, s, rn, rd, src2};
  endfunction

  function automatic op_item_t load_item(input logic [3:0] idx, input logic [DataW-1:0] val);
    op_item_t it;
    it            = '0;
    it.command    = CMD_LOAD;
    it.word       = $urandom();
    it.load_index = idx;
    it.load_value = val;
    return it;
  endfunction

  function automatic op_item_t exec_item(input logic [DataW-1:0] word);
    op_item_t it;
    it            = '0;
    it.command    = CMD_EXEC;
    it.word       = word;
    it.load_index = $urandom_range(0, 15);
    it.load_value = $urandom();
    return it;
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return 32'hffff_ffff;
      5: return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic op_item_t random_item();
    op_item_t        it;
    logic [OpcW-1:0] opc;
    int              sel;
    it            = '0;
    it.command    = CMD_EXEC;
    it.word       = $urandom();
    it.load_index = $urandom_range(0, 15);
    it.load_value = pick_value();
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      it.command = CMD_LOAD;
    end else if (sel < 88) begin
      case ($urandom_range(0, 4))
        0:       opc = OPC_MUL;
        1:       opc = OPC_SUB;
        2:       opc = OPC_ADD;
        3:       opc = OPC_CMP;
        default: opc = OPC_MOV;
      endcase
      it.word[27:26] = 2'b00;
      it.word[24:21] = opc;
      // plain register operand most of the time
      if (!it.word[25] && $urandom_range(0, 9) != 0) begin
        it.word[11:7] = 5'd0;
        it.word[4]    = 1'b0;
      end
      if (opc == OPC_CMP && $urandom_range(0, 3) != 0) it.word[20] = 1'b1;
      if (opc == OPC_CMP && $urandom_range(0, 3) != 0 && it.word[15:12] == PC_REG) begin
        it.word[15:12] = 4'd0;
      end
    end
    return it;
  endfunction

  task automatic next_wb_check(input result_t want, input result_t got);
    if (got.write_enable !== want.write_enable || got.dest_reg !== want.dest_reg ||
        got.dest_value !== want.dest_value || got.flags_written !== want.flags_written ||
        got.flags.n !== want.flags.n || got.flags.z !== want.flags.z ||
        got.flags.c !== want.flags.c || got.flags.v !== want.flags.v ||
        got.unsupported !== want.unsupported) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch: expected we=%0b rd=%0d val=%h fw=%0b nzcv=%b uns=%0b",
                 $realtime, want.write_enable, want.dest_reg, want.dest_value,
                 want.flags_written, want.flags, want.unsupported);
        $display("%0t:           got      we=%0b rd=%0d val=%h fw=%0b nzcv=%b uns=%0b",
                 $realtime, got.write_enable, got.dest_reg, got.dest_value,
                 got.flags_written, got.flags, got.unsupported);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end

  // item driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_if.valid || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (instr_queue.size() != 0) begin
          next_item = instr_queue.pop_front();
          in_if.valid            <= 1'b1;
          in_if.command          <= next_item.command;
          in_if.instruction_word <= next_item.word;
          in_if.load_index       <= next_item.load_index;
          in_if.load_value       <= next_item.load_value;
          in_gap = pick_gap(in_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result back pressure
  always @(negedge clk) begin
    if (rst_n) begin
      stall_now = out_stall;
      if (stall_now == 0 && (out_fire || $urandom_range(0, 7) == 0)) begin
        stall_now = pick_gap(out_calm);
      end
      if (stall_now > 0) begin
        out_if.ready <= 1'b0;
        out_stall = stall_now - 1;
      end else begin
        out_if.ready <= 1'b1;
        out_stall = 0;
      end
    end
  end

  // monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_n) begin
      in_fire  = in_if.valid && in_if.ready;
      out_fire = out_if.valid && out_if.ready;
      if (out_fire) begin
        observed.write_enable  = out_if.write_enable;
        observed.dest_reg      = out_if.dest_reg;
        observed.dest_value    = out_if.dest_value;
        observed.flags_written = out_if.flags_written;
        observed.flags.n       = out_if.flag_n;
        observed.flags.z       = out_if.flag_z;
        observed.flags.c       = out_if.flag_c;
        observed.flags.v       = out_if.flag_v;
        observed.unsupported   = out_if.unsupported;
        if (expected_writebacks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with none expected: we=%0b rd=%0d val=%h fw=%0b nzcv=%b uns=%0b",
                     $realtime, observed.write_enable, observed.dest_reg, observed.dest_value,
                     observed.flags_written, observed.flags, observed.unsupported);
          end
        end else begin
          next_wb_check(expected_writebacks.pop_front(), observed);
        end
      end
      if (in_fire) begin
        next_item.command    = command_e'(in_if.command);
        next_item.word       = in_if.instruction_word;
        next_item.load_index = in_if.load_index;
        next_item.load_value = in_if.load_value;
        expected_writebacks.push_back(execute_item(next_item));
        accepted_items++;
      end
    end
  end

  initial begin
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.command          = CMD_EXEC;
    in_if.instruction_word = '0;
    in_if.load_index       = '0;
    in_if.load_value       = '0;
    out_if.ready           = 1'b0;
    in_fire                = 1'b0;
    out_fire               = 1'b0;
    in_gap                 = 0;
    in_calm                = 0;
    out_stall              = 0;
    out_calm               = 0;
    mismatches             = 0;
    accepted_items         = 0;
    arch_flags             = '0;
    for (int i = 0; i < RegN; i++) arch_regs[i] = '0;

    // directed: extremes, every command, each corner
    instr_queue.push_back(load_item(4'd1, 32'hffff_ffff));
    instr_queue.push_back(load_item(4'd2, 32'h0000_0001));
    instr_queue.push_back(load_item(4'd3, 32'h8000_0000));
    instr_queue.push_back(load_item(4'd4, 32'h7fff_ffff));
    instr_queue.push_back(load_item(4'd15, 32'h1234_5678));
    instr_queue.push_back(load_item(4'd0, 32'h0000_0000));
    // add wraps, S set must leave flags alone
    instr_queue.push_back(exec_item(dp_word(OPC_ADD, 1'b0, 1'b1, 4'd1, 4'd5, 12'h002)));
    instr_queue.push_back(exec_item(dp_word(OPC_SUB, 1'b0, 1'b1, 4'd0, 4'd6, 12'h002)));
    // immediate: no rotation, rotate by 2, rotate by 30
    instr_queue.push_back(exec_item(dp_word(OPC_MOV, 1'b1, 1'b0, 4'd0, 4'd7, 12'h0ff)));
    instr_queue.push_back(exec_item(dp_word(OPC_MOV, 1'b1, 1'b0, 4'd0, 4'd7, 12'h1ff)));
    instr_queue.push_back(exec_item(dp_word(OPC_MOV, 1'b1, 1'b0, 4'd0, 4'd7, 12'hfff)));
    // register 15 read as ordinary register
    instr_queue.push_back(exec_item(dp_word(OPC_MOV, 1'b0, 1'b0, 4'd0, 4'd8, 12'h00f)));
    // multiply ignores I and bits 7:4
    instr_queue.push_back(exec_item(dp_word(OPC_MUL, 1'b1, 1'b1, 4'd9, 4'd0, 12'h1f1)));
    instr_queue.push_back(exec_item(dp_word(OPC_MUL, 1'b0, 1'b0, 4'd10, 4'd0, 12'h403)));
    // compare: signed overflow, equal, borrow
    instr_queue.push_back(exec_item(dp_word(OPC_CMP, 1'b0, 1'b1, 4'd3, 4'd0, 12'h002)));
    instr_queue.push_back(exec_item(dp_word(OPC_CMP, 1'b0, 1'b1, 4'd2, 4'd0, 12'h002)));
    instr_queue.push_back(exec_item(dp_word(OPC_CMP, 1'b0, 1'b1, 4'd0, 4'd0, 12'h002)));
    // compare with S clear, and with rd of 15, leaves flags
    instr_queue.push_back(exec_item(dp_word(OPC_CMP, 1'b1, 1'b0, 4'd2, 4'd0, 12'h001)));
    instr_queue.push_back(exec_item(dp_word(OPC_CMP, 1'b1, 1'b1, 4'd2, PC_REG, 12'h001)));
    // shifted register operands are unsupported
    instr_queue.push_back(exec_item(dp_word(OPC_ADD, 1'b0, 1'b0, 4'd1, 4'd11, 12'h082)));
    instr_queue.push_back(exec_item(dp_word(OPC_ADD, 1'b0, 1'b0, 4'd1, 4'd11, 12'h012)));
    instr_queue.push_back(exec_item(dp_word(OPC_CMP, 1'b0, 1'b1, 4'd1, 4'd0, 12'hf80)));
    // branch-exchange and an unknown opcode
    instr_queue.push_back(exec_item(32'he12f_ff11));
    instr_queue.push_back(exec_item(dp_word(4'hf, 1'b1, 1'b0, 4'd0, 4'd12, 12'h0aa)));
    instr_queue.push_back(exec_item(dp_word(OPC_ADD, 1'b1, 1'b0, 4'd15, PC_REG, 12'h804)));
    for (int i = 0; i < 1950; i++) instr_queue.push_back(random_item());
    total_items = instr_queue.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (accepted_items == total_items);
    wait (expected_writebacks.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
